>>> sv/slot_pool_oldest_evict_macros.svh
// Assertion macros for the slot pool allocator.
// Included by the controller and the datapath; needs clk and rst_n in scope.
`ifndef SLOT_POOL_OLDEST_EVICT_MACROS_SVH
`define SLOT_POOL_OLDEST_EVICT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SPOE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define SPOE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/spoe_pkg.sv
// Shared types and constants for the slot pool allocator.
// No dependencies; used by spoe_ctrl, spoe_dp and slot_pool_oldest_evict.
package spoe_pkg;

  localparam int NUM_SLOTS = 256;
  localparam int SLOT_W    = $clog2(NUM_SLOTS);
  localparam int LINK_W    = $clog2(NUM_SLOTS + 1);
  localparam int FIELD_W   = 8;
  localparam int OUT_W     = 24;

  localparam logic [LINK_W-1:0] NIL = LINK_W'(NUM_SLOTS);

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_REL_LINK = 7'b0000010,
    S_REL_PUSH = 7'b0000100,
    S_ALC_RD   = 7'b0001000,
    S_ALC_POP  = 7'b0010000,
    S_ALC_LINK = 7'b0100000,
    S_DONE     = 7'b1000000
  } state_t;

  typedef struct packed {
    logic start;
    logic rel_link;
    logic rel_push;
    logic alloc_rd;
    logic alloc_pop;
    logic alloc_link;
    logic set_status;
  } cmd_t;

  typedef struct packed {
    logic req_free;
    logic fh_nil;
    logic oldest_nil;
    logic kind_free;
    logic rel_bad;
  } sts_t;

  typedef struct packed {
    logic               status;
    logic [FIELD_W-1:0] evicted_slot;
    logic               evicted_flag;
    logic [FIELD_W-1:0] granted_slot;
  } res_t;

endpackage

>>> sv/spoe_ctrl.sv
// Sequencing state machine for the slot pool allocator.
// Depends on spoe_pkg and slot_pool_oldest_evict_macros.svh.
`include "slot_pool_oldest_evict_macros.svh"

module spoe_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            out_free,
  input  spoe_pkg::sts_t  sts,
  output logic            in_ready,
  output logic            out_load,
  output spoe_pkg::cmd_t  cmd
);

  spoe_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= spoe_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == spoe_pkg::S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    out_load  = 1'b0;
    unique case (state_r)
      spoe_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          if (sts.req_free) begin
            state_nxt = spoe_pkg::S_REL_LINK;
          end else if (!sts.fh_nil) begin
            state_nxt = spoe_pkg::S_ALC_POP;
          end else if (!sts.oldest_nil) begin
            state_nxt = spoe_pkg::S_REL_LINK;
          end else begin
            state_nxt = spoe_pkg::S_DONE;
          end
        end
      end
      spoe_pkg::S_REL_LINK: begin
        if (sts.rel_bad) begin
          cmd.set_status = 1'b1;
          state_nxt      = spoe_pkg::S_DONE;
        end else begin
          cmd.rel_link = 1'b1;
          state_nxt    = spoe_pkg::S_REL_PUSH;
        end
      end
      spoe_pkg::S_REL_PUSH: begin
        cmd.rel_push = 1'b1;
        state_nxt    = sts.kind_free ? spoe_pkg::S_DONE : spoe_pkg::S_ALC_RD;
      end
      spoe_pkg::S_ALC_RD: begin
        cmd.alloc_rd = 1'b1;
        state_nxt    = spoe_pkg::S_ALC_POP;
      end
      spoe_pkg::S_ALC_POP: begin
        cmd.alloc_pop = 1'b1;
        state_nxt     = spoe_pkg::S_ALC_LINK;
      end
      spoe_pkg::S_ALC_LINK: begin
        cmd.alloc_link = 1'b1;
        state_nxt      = spoe_pkg::S_DONE;
      end
      spoe_pkg::S_DONE: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = spoe_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = spoe_pkg::S_IDLE;
      end
    endcase
  end

  `SPOE_ASSERT_NEXT(a_start_leaves_idle, cmd.start, state_r != spoe_pkg::S_IDLE, "start did not leave idle")
  `SPOE_ASSERT_NOW(a_status_on_free, cmd.set_status, sts.kind_free, "error status on allocate")
  `SPOE_ASSERT_NEXT(a_pop_then_link, cmd.alloc_pop, cmd.alloc_link, "pop not followed by link")

endmodule

>>> sv/spoe_dp.sv
// Datapath of the slot pool allocator: link memories, active marks, list heads.
// Depends on spoe_pkg and slot_pool_oldest_evict_macros.svh.
`include "slot_pool_oldest_evict_macros.svh"

module spoe_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_kind,
  input  logic [spoe_pkg::FIELD_W-1:0] in_slot,
  input  spoe_pkg::cmd_t               cmd,
  output spoe_pkg::sts_t               sts,
  output spoe_pkg::res_t               res
);

  logic [spoe_pkg::LINK_W-1:0] free_head_r, newest_r, oldest_r, hw_r;
  logic [spoe_pkg::SLOT_W-1:0] s_r, rd_addr_r, start_slot, rd_addr;
  logic                        kind_r, ok_r, fresh_r, rd_en;

  logic [spoe_pkg::LINK_W-1:0] next_mem [spoe_pkg::NUM_SLOTS];
  logic [spoe_pkg::LINK_W-1:0] prev_mem [spoe_pkg::NUM_SLOTS];
  logic                        act_mem  [spoe_pkg::NUM_SLOTS];
  logic [spoe_pkg::LINK_W-1:0] next_q, prev_q, next_rd;
  logic                        act_q, act_rd;

  logic                        nx_we, pv_we, ac_we, ac_wd;
  logic [spoe_pkg::SLOT_W-1:0] nx_wa, pv_wa;
  logic [spoe_pkg::LINK_W-1:0] nx_wd, pv_wd;

  logic [spoe_pkg::FIELD_W-1:0] granted_r, evslot_r;
  logic                         evflag_r, status_r;
  logic                         fh_nil, oldest_nil, start_evict;

  assign fh_nil      = !(free_head_r < spoe_pkg::NIL);
  assign oldest_nil  = !(oldest_r < spoe_pkg::NIL);
  assign start_evict = !in_kind && fh_nil && !oldest_nil;

  assign start_slot = in_kind ? spoe_pkg::SLOT_W'(in_slot)
                    : (fh_nil ? oldest_r[spoe_pkg::SLOT_W-1:0]
                              : free_head_r[spoe_pkg::SLOT_W-1:0]);
  assign rd_addr = cmd.alloc_rd ? free_head_r[spoe_pkg::SLOT_W-1:0] : start_slot;
  assign rd_en   = cmd.start | cmd.alloc_rd;

  // Slots at or above the fill count were never handed out: next is i+1, not active.
  assign next_rd = fresh_r ? (spoe_pkg::LINK_W'(rd_addr_r) + spoe_pkg::LINK_W'(1)) : next_q;
  assign act_rd  = !fresh_r && act_q;

  assign sts.req_free   = in_kind;
  assign sts.fh_nil     = fh_nil;
  assign sts.oldest_nil = oldest_nil;
  assign sts.kind_free  = kind_r;
  assign sts.rel_bad    = kind_r && (!ok_r || !act_rd);

  assign res.granted_slot = granted_r;
  assign res.evicted_flag = evflag_r;
  assign res.evicted_slot = evslot_r;
  assign res.status       = status_r;

  always_comb begin
    nx_we = 1'b0;
    nx_wa = s_r;
    nx_wd = free_head_r;
    pv_we = 1'b0;
    pv_wa = s_r;
    pv_wd = spoe_pkg::NIL;
    ac_we = 1'b0;
    ac_wd = 1'b0;
    if (cmd.rel_link) begin
      nx_we = (prev_q < spoe_pkg::NIL);
      nx_wa = prev_q[spoe_pkg::SLOT_W-1:0];
      nx_wd = next_rd;
      pv_we = (next_rd < spoe_pkg::NIL);
      pv_wa = next_rd[spoe_pkg::SLOT_W-1:0];
      pv_wd = prev_q;
    end else if (cmd.rel_push) begin
      nx_we = 1'b1;
      ac_we = 1'b1;
    end else if (cmd.alloc_pop) begin
      nx_we = 1'b1;
      nx_wd = newest_r;
      pv_we = 1'b1;
      ac_we = 1'b1;
      ac_wd = 1'b1;
    end else if (cmd.alloc_link) begin
      pv_we = (newest_r < spoe_pkg::NIL);
      pv_wa = newest_r[spoe_pkg::SLOT_W-1:0];
      pv_wd = spoe_pkg::LINK_W'(s_r);
    end
  end

  always_ff @(posedge clk) begin
    if (nx_we) begin
      next_mem[nx_wa] <= nx_wd;
    end
    if (rd_en) begin
      next_q <= next_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (pv_we) begin
      prev_mem[pv_wa] <= pv_wd;
    end
    if (rd_en) begin
      prev_q <= prev_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (ac_we) begin
      act_mem[s_r] <= ac_wd;
    end
    if (rd_en) begin
      act_q <= act_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_head_r <= '0;
      newest_r    <= spoe_pkg::NIL;
      oldest_r    <= spoe_pkg::NIL;
      hw_r        <= '0;
    end else begin
      if (cmd.rel_link) begin
        if (!(prev_q < spoe_pkg::NIL)) begin
          newest_r <= next_rd;
        end
        if (!(next_rd < spoe_pkg::NIL)) begin
          oldest_r <= prev_q;
        end
      end
      if (cmd.rel_push) begin
        free_head_r <= spoe_pkg::LINK_W'(s_r);
      end
      if (cmd.alloc_pop) begin
        free_head_r <= next_rd;
        if (spoe_pkg::LINK_W'(s_r) >= hw_r) begin
          hw_r <= hw_r + spoe_pkg::LINK_W'(1);
        end
      end
      if (cmd.alloc_link) begin
        if (!(newest_r < spoe_pkg::NIL)) begin
          oldest_r <= spoe_pkg::LINK_W'(s_r);
        end
        newest_r <= spoe_pkg::LINK_W'(s_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_addr_r <= rd_addr;
      fresh_r   <= (spoe_pkg::LINK_W'(rd_addr) >= hw_r);
    end
    if (cmd.start) begin
      kind_r    <= in_kind;
      s_r       <= start_slot;
      ok_r      <= ({24'd0, in_slot} < 32'(spoe_pkg::NUM_SLOTS));
      evflag_r  <= start_evict;
      evslot_r  <= start_evict ? spoe_pkg::FIELD_W'(oldest_r[spoe_pkg::SLOT_W-1:0]) : '0;
      granted_r <= '0;
      status_r  <= 1'b0;
    end
    if (cmd.alloc_pop) begin
      granted_r <= spoe_pkg::FIELD_W'(s_r);
    end
    if (cmd.set_status) begin
      status_r <= 1'b1;
    end
  end

  `SPOE_ASSERT_NEXT(a_pop_moves_head, cmd.alloc_pop, free_head_r != spoe_pkg::LINK_W'(s_r), "free head still on granted slot")

endmodule

>>> sv/slot_pool_oldest_evict.sv
// Slot pool allocator with oldest-slot eviction. Every word in gives one result word.
// An allocate pops the free head (S_ALC_POP) and links it as newest (S_ALC_LINK);
// with no free slot it first frees the oldest, if any (S_REL_LINK, S_REL_PUSH,
// S_ALC_RD). A free unlinks the slot and pushes it (S_REL_LINK, S_REL_PUSH), and
// stops after S_REL_LINK on an inactive slot. Each link memory has one write port.
// A finished result waits in the output register while the next word is taken.
// No clearing pass after reset: a fill count stands in for untouched link entries.
// Depends on spoe_pkg, spoe_ctrl and spoe_dp.
module slot_pool_oldest_evict (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [7:0]                 in_tdata,   // [7:0] slot_to_free
  input  logic                       in_tuser,   // [0] kind
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [spoe_pkg::OUT_W-1:0] out_tdata   // [7:0] granted_slot, [8] evicted_flag,
                                                 // [16:9] evicted_slot, [17] status
);

  spoe_pkg::cmd_t cmd;
  spoe_pkg::sts_t sts;
  spoe_pkg::res_t res;
  logic           out_free, out_load, out_valid_r;
  logic [spoe_pkg::OUT_W-1:0] out_data_r;

  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  spoe_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .out_free (out_free),
    .sts      (sts),
    .in_ready (in_tready),
    .out_load (out_load),
    .cmd      (cmd)
  );

  spoe_dp u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_kind (in_tuser),
    .in_slot (in_tdata),
    .cmd     (cmd),
    .sts     (sts),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= {6'd0, res.status, res.evicted_slot, res.evicted_flag, res.granted_slot};
    end
  end

endmodule
